@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rational arithmetic unit checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define RAU_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rau same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled in reset.
`define RAU_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rau next-cycle check failed");

`endif

@@ hdl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Payload structs, command codes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_EQ   = 3'd4;
   localparam logic [2:0] CMD_NORM = 3'd5;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZERO = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               is_equal;
      logic [1:0]         status;
   } rsp_type;

endpackage

@@ hdl/rau_mul.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Shared unsigned magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int W = 32
) (
   input  logic             clock,
   input  logic [W-1:0]     x,
   input  logic [W-1:0]     y,
   output logic [2*W-1:0]   prod_ff
);
   logic [2*W-1:0] prod_in;

   assign prod_in = (2*W)'(x) * (2*W)'(y);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

@@ hdl/rau_gcd.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit GCD engine
// Binary GCD, one compare-and-subtract or shift step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] x,
   input  logic [DW-1:0] y,
   output logic          done_ff,
   output logic [DW-1:0] g_ff
);
   localparam int KW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_in;
   logic [DW-1:0] u_ff, u_in, v_ff, v_in, g_in;
   logic [KW-1:0] k_ff, k_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      if (start) begin
         busy_in = 1'b1;
         u_in    = x;
         v_in    = y;
         k_in    = '0;
      end else if (busy_ff) begin
         if (u_ff == '0 || v_ff == '0) begin
            g_in    = (u_ff | v_ff) << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end
endmodule

@@ hdl/rau_div.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done_ff,
   output logic [DW-1:0] quo_ff
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in, done_in;
   logic [DW-1:0] rem_ff, rem_in, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end
endmodule

@@ hdl/rational_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, compares or normalizes fractions and
// returns the result reduced by its GCD with a positive denominator; a compare sets only is_equal.
//
//   Channel  Ports                         Role
//   request  req_valid req_stall req_payload   operands and command in
//   response rsp_valid rsp_stall rsp_payload   reduced fraction and status out
//
// An item takes three products on the shared multiplier (none for normalize),
// one combine step, a binary GCD and two divisions by the GCD; compares, error
// cases and zero results go to the response without the GCD and divisions.
// One item is in flight at a time; req_stall is high from when its beat is taken until its response is accepted.
// Reset is synchronous and leaves the block idle with no response pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
   parameter int WORD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rau_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rau_pkg::rsp_type  rsp_payload
);
   import rau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int DW = 2 * WORD_BITS;
   localparam logic [DW-1:0] HALF = {{(DW-1){1'b0}}, 1'b1} << (W - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL_A = 4'd1;
   localparam logic [3:0] S_MUL_B = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_GCD_G = 4'd4;
   localparam logic [3:0] S_GCD_W = 4'd5;
   localparam logic [3:0] S_DVN_G = 4'd6;
   localparam logic [3:0] S_DVN_W = 4'd7;
   localparam logic [3:0] S_DVD_G = 4'd8;
   localparam logic [3:0] S_DVD_W = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [1:0]    idx_ff, idx_in;
   logic [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic [W-1:0]  an_in, ad_in, bn_in, bd_in;
   logic          an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic          an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [DW-1:0] p_mag_ff [3];
   logic [DW-1:0] p_mag_in [3];
   logic          p_neg_ff [3];
   logic          p_neg_in [3];
   logic [DW-1:0] num_ff, num_in, den_ff, den_in, nq_ff, nq_in;
   logic          neg_ff, neg_in;
   rsp_type       rsp_ff, rsp_in;

   logic [W-1:0]  mx, my;
   logic          mx_neg, my_neg;
   logic [DW-1:0] prod;
   logic          gcd_done, div_done;
   logic [DW-1:0] gcd_g, div_quo, div_num;
   logic          b_neg_eff;
   logic [DW-1:0] sum_mag;
   logic          sum_neg;
   logic [31:0]   n32;
   logic          ovf;

   function automatic logic [W:0] sx(input logic [31:0] raw);
      logic [W-1:0] v;
      begin
         v = raw[W-1:0];
         sx = {v[W-1], v[W-1] ? (W'(0) - v) : v};
      end
   endfunction

   // Operand selection for the three cross products.
   always_comb begin
      case (idx_ff)
         2'd0: begin
            mx = an_ff; mx_neg = an_neg_ff;
            my = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
            my_neg = (cmd_ff == CMD_MUL) ? bn_neg_ff : bd_neg_ff;
         end
         2'd1: begin
            mx = bn_ff; mx_neg = bn_neg_ff;
            my = ad_ff; my_neg = ad_neg_ff;
         end
         default: begin
            mx = ad_ff; mx_neg = ad_neg_ff;
            my = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
            my_neg = (cmd_ff == CMD_DIV) ? bn_neg_ff : bd_neg_ff;
         end
      endcase
   end

   rau_mul #(.W(W)) u_mul (
      .clock   (clock),
      .x       (mx),
      .y       (my),
      .prod_ff (prod)
   );

   rau_gcd #(.DW(DW)) u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_GCD_G),
      .x       (num_ff),
      .y       (den_ff),
      .done_ff (gcd_done),
      .g_ff    (gcd_g)
   );

   assign div_num = (state_ff == S_DVN_G) ? num_ff : den_ff;

   rau_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == S_DVN_G) || (state_ff == S_DVD_G)),
      .dividend (div_num),
      .divisor  (gcd_g),
      .done_ff  (div_done),
      .quo_ff   (div_quo)
   );

   // Sign-magnitude add of the first product and the second, negated for subtract.
   always_comb begin
      b_neg_eff = p_neg_ff[1] ^ ((cmd_ff == CMD_SUB) && (p_mag_ff[1] != '0));
      if (p_neg_ff[0] == b_neg_eff) begin
         sum_mag = p_mag_ff[0] + p_mag_ff[1];
         sum_neg = p_neg_ff[0];
      end else if (p_mag_ff[0] >= p_mag_ff[1]) begin
         sum_mag = p_mag_ff[0] - p_mag_ff[1];
         sum_neg = p_neg_ff[0];
      end else begin
         sum_mag = p_mag_ff[1] - p_mag_ff[0];
         sum_neg = b_neg_eff;
      end
   end

   assign n32 = 32'(nq_ff[W-1:0]);
   assign ovf = (div_quo > HALF - DW'(1)) || (nq_ff > (neg_ff ? HALF : HALF - DW'(1)));

   always_comb begin
      logic [W:0] sa, sb, sc, sd;
      sa = sx(req_payload.a_num);
      sb = sx(req_payload.a_den);
      sc = sx(req_payload.b_num);
      sd = sx(req_payload.b_den);
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      an_neg_in = an_neg_ff; ad_neg_in = ad_neg_ff;
      bn_neg_in = bn_neg_ff; bd_neg_in = bd_neg_ff;
      p_mag_in  = p_mag_ff;
      p_neg_in  = p_neg_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      nq_in     = nq_ff;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload.cmd;
               an_in = sa[W-1:0]; an_neg_in = sa[W];
               ad_in = sb[W-1:0]; ad_neg_in = sb[W];
               bn_in = sc[W-1:0]; bn_neg_in = sc[W];
               bd_in = sd[W-1:0]; bd_neg_in = sd[W];
               idx_in = 2'd0;
               rsp_in = '{res_num: '0, res_den: 31'd1, is_equal: 1'b0, status: STAT_OK};
               p_mag_in[0] = DW'(sa[W-1:0]); p_neg_in[0] = sa[W];
               p_mag_in[2] = DW'(sb[W-1:0]); p_neg_in[2] = sb[W];
               if (req_payload.cmd > CMD_NORM) begin
                  state_in = S_OUT;
               end else if (sb[W-1:0] == '0 ||
                            (req_payload.cmd != CMD_NORM && sd[W-1:0] == '0) ||
                            (req_payload.cmd == CMD_DIV && sc[W-1:0] == '0)) begin
                  rsp_in.status = STAT_ZERO;
                  state_in = S_OUT;
               end else if (req_payload.cmd == CMD_NORM) begin
                  state_in = S_SUM;
               end else begin
                  state_in = S_MUL_A;
               end
            end
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: begin
            p_mag_in[idx_ff] = prod;
            p_neg_in[idx_ff] = (prod != '0) && (mx_neg != my_neg);
            if (idx_ff == 2'd2) begin
               state_in = S_SUM;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_MUL_A;
            end
         end
         S_SUM: begin
            if (cmd_ff == CMD_EQ) begin
               rsp_in.is_equal = (p_neg_ff[0] == p_neg_ff[1]) &&
                                 (p_mag_ff[0] == p_mag_ff[1]);
               state_in = S_OUT;
            end else begin
               if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
                  num_in = sum_mag;
                  neg_in = sum_neg != p_neg_ff[2];
               end else begin
                  num_in = p_mag_ff[0];
                  neg_in = p_neg_ff[0] != p_neg_ff[2];
               end
               den_in = p_mag_ff[2];
               state_in = (num_in == '0) ? S_OUT : S_GCD_G;
            end
         end
         S_GCD_G: state_in = S_GCD_W;
         S_GCD_W: if (gcd_done) state_in = S_DVN_G;
         S_DVN_G: state_in = S_DVN_W;
         S_DVN_W: begin
            if (div_done) begin
               nq_in    = div_quo;
               state_in = S_DVD_G;
            end
         end
         S_DVD_G: state_in = S_DVD_W;
         S_DVD_W: begin
            if (div_done) begin
               if (ovf) begin
                  rsp_in.status = STAT_OVF;
               end else begin
                  rsp_in.res_num = neg_ff ? (32'd0 - n32) : n32;
                  rsp_in.res_den = 31'(div_quo);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      an_neg_ff <= an_neg_in; ad_neg_ff <= ad_neg_in;
      bn_neg_ff <= bn_neg_in; bd_neg_ff <= bd_neg_in;
      p_mag_ff <= p_mag_in;
      p_neg_ff <= p_neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      nq_ff  <= nq_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_payload = rsp_ff;
endmodule

@@ hdl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on the response channel and the request flow.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rau_pkg::rsp_type  rsp_payload
);
   import rau_pkg::*;

   logic neutral_frac;

   assign neutral_frac = (rsp_payload.res_num == 32'sd0) && (rsp_payload.res_den == 31'd1) &&
                         !rsp_payload.is_equal;

   // A held response beat keeps its contents.
   `RAU_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // The block is busy right after it takes a beat.
   `RAU_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // Denominators are never zero.
   `RAU_ASSERT_IMP(a_den_nonzero, rsp_valid, rsp_payload.res_den != 31'd0)

   // An error status always comes with the neutral fraction.
   `RAU_ASSERT_IMP(a_err_zero, rsp_valid && rsp_payload.status != STAT_OK, neutral_frac)
endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);
